// ===== rtl/core/cda_pkg.sv =====
// Shared types, codes and calendar helpers for the calendar date adder.
`default_nettype none

package cda_pkg;

    // Unit codes carried in the action field
    localparam logic [2:0] ACT_DAYS      = 3'd0;
    localparam logic [2:0] ACT_WEEKS     = 3'd1;
    localparam logic [2:0] ACT_MONTHS    = 3'd2;
    localparam logic [2:0] ACT_YEARS     = 3'd3;
    localparam logic [2:0] ACT_DECADES   = 3'd4;
    localparam logic [2:0] ACT_CENTURIES = 3'd5;
    localparam logic [2:0] ACT_MILLENNIA = 3'd6;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [13:0] MAX_YEAR = 14'd9999;

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [9:0]  amount;
    } cda_in_t;

    typedef struct packed {
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [13:0] end_year;
        logic [1:0]  status;
    } cda_out_t;

    // Date held as day, month, century and year within century
    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] cen;
        logic [6:0] yy;
    } cda_date_t;

    typedef struct packed {
        logic month_step;
    } cda_step_ctl_t;

    typedef struct packed {
        cda_date_t  next;
        logic       year_inc;
        logic [4:0] cur_days;
        logic       cur_leap;
    } cda_step_res_t;

    function automatic logic leap_year(input logic [7:0] cen, input logic [6:0] yy);
        logic res;
        if (yy == 7'd0)
            res = (cen[1:0] == 2'd0);
        else
            res = (yy[1:0] == 2'd0);
        return res;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] res;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: res = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    res = 5'd30;
            4'd2:                                       res = leap ? 5'd29 : 5'd28;
            default:                                    res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cda_in_if.sv =====
// Command channel of the calendar date adder: valid, ready and a start date.
`default_nettype none

interface cda_in_if;
    logic             valid;
    logic             ready;
    cda_pkg::cda_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cda_out_if.sv =====
// Result channel of the calendar date adder: valid, ready and the advanced date.
`default_nettype none

interface cda_out_if;
    logic              valid;
    logic              ready;
    cda_pkg::cda_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cda_step.sv =====
// Shared calendar step unit: advance a date by one day or one month.
`default_nettype none

module cda_step (
    input  wire cda_pkg::cda_date_t     cur,
    input  wire cda_pkg::cda_step_ctl_t ctl,
    output cda_pkg::cda_step_res_t      res
);

    logic       cur_leap;
    logic [4:0] cur_days;
    logic       roll_month;
    logic [3:0] m_inc;
    logic       y_inc;
    logic [7:0] cen_inc;
    logic [6:0] yy_inc;
    logic       new_leap;
    logic [4:0] new_days;

    assign cur_leap = cda_pkg::leap_year(cur.cen, cur.yy);
    assign cur_days = cda_pkg::month_days(cur.month, cur_leap);

    // A day step crosses into the next month at the month's last day
    assign roll_month = ctl.month_step || (cur.day >= cur_days);

    always_comb
    begin
        if (cur.month >= 4'd12)
        begin
            m_inc = 4'd1;
            y_inc = 1'b1;
        end
        else
        begin
            m_inc = cur.month + 4'd1;
            y_inc = 1'b0;
        end
    end

    always_comb
    begin
        if (!y_inc)
        begin
            cen_inc = cur.cen;
            yy_inc  = cur.yy;
        end
        else if (cur.yy == 7'd99)
        begin
            cen_inc = cur.cen + 8'd1;
            yy_inc  = 7'd0;
        end
        else
        begin
            cen_inc = cur.cen;
            yy_inc  = cur.yy + 7'd1;
        end
    end

    assign new_leap = cda_pkg::leap_year(cen_inc, yy_inc);
    assign new_days = cda_pkg::month_days(m_inc, new_leap);

    always_comb
    begin
        res.cur_days = cur_days;
        res.cur_leap = cur_leap;
        if (ctl.month_step)
        begin
            // Clamp the day to the length of the month reached
            res.next.day   = (cur.day > new_days) ? new_days : cur.day;
            res.next.month = m_inc;
            res.next.cen   = cen_inc;
            res.next.yy    = yy_inc;
            res.year_inc   = y_inc;
        end
        else if (roll_month)
        begin
            res.next.day   = 5'd1;
            res.next.month = m_inc;
            res.next.cen   = cen_inc;
            res.next.yy    = yy_inc;
            res.year_inc   = y_inc;
        end
        else
        begin
            res.next.day   = cur.day + 5'd1;
            res.next.month = cur.month;
            res.next.cen   = cur.cen;
            res.next.yy    = cur.yy;
            res.year_inc   = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/calendar_date_adder.sv =====
// Top level of the calendar date adder: sequencer, year split and result register.
//
// Usage: the cmd channel takes one transaction holding a start date, a unit
// (days, weeks, months, years, decades, centuries, millennia) and an amount.
// The res channel returns one transaction per command: the advanced date and
// a status (ok, invalid start date, year past 9999). On a non-ok status the
// start date is returned unchanged.
// Sequence: setup (year split into century and year within century, date
// check), then one step per day or per month through the shared step unit
// until the count ends, then the load of the result register. Year-based
// units instead add the scaled amount, check the sum, split the new year
// again and clamp Feb 29. The date registers advance one day or one month
// per cycle through the step unit while the count runs.
// Throughput: one command at a time; cmd.ready is high only while the
// sequencer is idle. A finished result sits in the output register, so a new
// command is taken while the receiver still holds off res.ready. If a second
// result is done before the first is taken, the sequencer holds it until the
// output register frees up.
// Reset: rst_n clears the sequencer and the output valid flag at once.
`default_nettype none

module calendar_date_adder (
    input  wire       clk,
    input  wire       rst_n,
    cda_in_if.sink    cmd,
    cda_out_if.source res
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SPLIT_MUL = 4'd1;
    localparam logic [3:0] ST_SPLIT_SUB = 4'd2;
    localparam logic [3:0] ST_CHECK     = 4'd3;
    localparam logic [3:0] ST_DAYS      = 4'd4;
    localparam logic [3:0] ST_MONTHS    = 4'd5;
    localparam logic [3:0] ST_YEAR_ADD  = 4'd6;
    localparam logic [3:0] ST_YEAR_CHK  = 4'd7;
    localparam logic [3:0] ST_CLAMP     = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    localparam logic [9:0] MULT_YEARS     = 10'd1;
    localparam logic [9:0] MULT_DECADES   = 10'd10;
    localparam logic [9:0] MULT_CENTURIES = 10'd100;
    localparam logic [9:0] MULT_MILLENNIA = 10'd1000;

    // Control state
    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // Working data
    cda_pkg::cda_in_t   cmd_reg, cmd_next;
    logic [4:0]         d_reg, d_next;
    logic [3:0]         m_reg, m_next;
    logic [13:0]        y_reg, y_next;
    logic [7:0]         cen_reg, cen_next;
    logic [6:0]         yy_reg, yy_next;
    logic [12:0]        cnt_reg, cnt_next;
    logic [26:0]        prod_reg, prod_next;
    logic [19:0]        sum_reg, sum_next;
    logic [1:0]         status_reg, status_next;
    logic               split_sel_reg, split_sel_next;
    cda_pkg::cda_out_t  out_reg, out_next;

    cda_pkg::cda_date_t     step_cur;
    cda_pkg::cda_step_ctl_t step_ctl;
    cda_pkg::cda_step_res_t step_res;

    logic        cmd_fire;
    logic        out_load;
    logic [7:0]  split_cen;
    logic [14:0] cen_x100;
    logic [14:0] yy_wide;
    logic [9:0]  year_mult;
    logic [19:0] year_prod;
    logic        date_ok;
    logic [1:0]  final_status;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // Shared step unit works on the current date registers
    assign step_cur.day   = d_reg;
    assign step_cur.month = m_reg;
    assign step_cur.cen   = cen_reg;
    assign step_cur.yy    = yy_reg;
    assign step_ctl.month_step = (state_reg == ST_MONTHS);

    cda_step u_step (
        .cur (step_cur),
        .ctl (step_ctl),
        .res (step_res)
    );

    // Year split: century from the registered reciprocal product
    assign split_cen = prod_reg[cda_pkg::RECIP_SHIFT +: 8];
    assign cen_x100  = {1'b0, split_cen, 6'd0} + {2'b0, split_cen, 5'd0}
                     + {5'b0, split_cen, 2'd0};
    assign yy_wide   = {1'b0, y_reg} - cen_x100;

    always_comb
    begin
        case (cmd_reg.action)
            cda_pkg::ACT_YEARS:     year_mult = MULT_YEARS;
            cda_pkg::ACT_DECADES:   year_mult = MULT_DECADES;
            cda_pkg::ACT_CENTURIES: year_mult = MULT_CENTURIES;
            default:                year_mult = MULT_MILLENNIA;
        endcase
    end

    assign year_prod = 20'(cmd_reg.amount * year_mult);

    // Start date check; the step unit reports the start month's length here
    assign date_ok = (cmd_reg.start_month >= 4'd1) && (cmd_reg.start_month <= 4'd12)
                  && (cmd_reg.start_day >= 5'd1)
                  && (cmd_reg.start_day <= step_res.cur_days)
                  && (cmd_reg.start_year <= cda_pkg::MAX_YEAR);

    assign final_status = (status_reg != cda_pkg::STAT_OK) ? status_reg :
                          (y_reg > cda_pkg::MAX_YEAR) ? cda_pkg::STAT_OVERFLOW :
                          cda_pkg::STAT_OK;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        y_next         = y_reg;
        cen_next       = cen_reg;
        yy_next        = yy_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        status_next    = status_reg;
        split_sel_next = split_sel_reg;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    cmd_next       = cmd.data;
                    d_next         = cmd.data.start_day;
                    m_next         = cmd.data.start_month;
                    y_next         = cmd.data.start_year;
                    status_next    = cda_pkg::STAT_OK;
                    split_sel_next = 1'b0;
                    state_next     = ST_SPLIT_MUL;
                end
            end

            ST_SPLIT_MUL:
            begin
                prod_next  = 27'(y_reg * cda_pkg::RECIP_100);
                state_next = ST_SPLIT_SUB;
            end

            ST_SPLIT_SUB:
            begin
                cen_next   = split_cen;
                yy_next    = yy_wide[6:0];
                state_next = split_sel_reg ? ST_CLAMP : ST_CHECK;
            end

            ST_CHECK:
            begin
                if (!date_ok)
                begin
                    status_next = cda_pkg::STAT_INVALID;
                    state_next  = ST_DONE;
                end
                else if (cmd_reg.action == cda_pkg::ACT_DAYS)
                begin
                    cnt_next   = {3'd0, cmd_reg.amount};
                    state_next = ST_DAYS;
                end
                else if (cmd_reg.action == cda_pkg::ACT_WEEKS)
                begin
                    cnt_next   = {cmd_reg.amount, 3'd0} - {3'd0, cmd_reg.amount};
                    state_next = ST_DAYS;
                end
                else if (cmd_reg.action == cda_pkg::ACT_MONTHS)
                begin
                    cnt_next   = {3'd0, cmd_reg.amount};
                    state_next = ST_MONTHS;
                end
                else if (cmd_reg.action == cda_pkg::ACT_YEARS
                      || cmd_reg.action == cda_pkg::ACT_DECADES
                      || cmd_reg.action == cda_pkg::ACT_CENTURIES
                      || cmd_reg.action == cda_pkg::ACT_MILLENNIA)
                begin
                    state_next = ST_YEAR_ADD;
                end
                else
                begin
                    // Unused unit code: pass the start date through
                    state_next = ST_DONE;
                end
            end

            ST_DAYS, ST_MONTHS:
            begin
                if (cnt_reg == 13'd0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    d_next   = step_res.next.day;
                    m_next   = step_res.next.month;
                    cen_next = step_res.next.cen;
                    yy_next  = step_res.next.yy;
                    if (step_res.year_inc)
                        y_next = y_reg + 14'd1;
                    cnt_next = cnt_reg - 13'd1;
                end
            end

            ST_YEAR_ADD:
            begin
                sum_next   = {6'd0, cmd_reg.start_year} + year_prod;
                state_next = ST_YEAR_CHK;
            end

            ST_YEAR_CHK:
            begin
                if (sum_reg > {6'd0, cda_pkg::MAX_YEAR})
                begin
                    status_next = cda_pkg::STAT_OVERFLOW;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // Split the new year to get its leap flag
                    y_next         = sum_reg[13:0];
                    split_sel_next = 1'b1;
                    state_next     = ST_SPLIT_MUL;
                end
            end

            ST_CLAMP:
            begin
                if (m_reg == 4'd2 && d_reg == 5'd29 && !step_res.cur_leap)
                    d_next = 5'd28;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    out_next.status = final_status;
                    if (final_status != cda_pkg::STAT_OK)
                    begin
                        out_next.end_day   = cmd_reg.start_day;
                        out_next.end_month = cmd_reg.start_month;
                        out_next.end_year  = cmd_reg.start_year;
                    end
                    else
                    begin
                        out_next.end_day   = d_reg;
                        out_next.end_month = m_reg;
                        out_next.end_year  = y_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        d_reg         <= d_next;
        m_reg         <= m_next;
        y_reg         <= y_next;
        cen_reg       <= cen_next;
        yy_reg        <= yy_next;
        cnt_reg       <= cnt_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        status_reg    <= status_next;
        split_sel_reg <= split_sel_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/calendar_date_adder_tb.sv =====
// Self-checking testbench for the calendar date adder: directed and random date adds.
`default_nettype none

module calendar_date_adder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Unit code 7 has no meaning: the block passes the start date through
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int AMOUNT_CAP = 1023;

    // Random item count and run-control limits
    localparam int RANDOM_CMDS    = 80;
    // Weeks at the largest amount keep the block busy with no transaction on either
    // side; the limit allows several times that run before giving up
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 20;

    // Holds the expected results in command order and checks each returned date
    class date_scoreboard;
        cda_pkg::cda_out_t due_q[$];
        int                errors = 0;

        static function bit is_leap_year(input int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int month_length(input int y, input int m);
            if (m < 1 || m > 12)
                return 0;
            case (m)
                2:           return is_leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // Advance the start date by the amount of units, as the block should
        function cda_pkg::cda_out_t advance_date(input cda_pkg::cda_in_t c);
            cda_pkg::cda_out_t r;
            int                d;
            int                m;
            int                y;
            int                n;
            int                steps;
            int                scale;
            logic [1:0]        st;
            d  = c.start_day;
            m  = c.start_month;
            y  = c.start_year;
            n  = (c.amount > AMOUNT_CAP) ? AMOUNT_CAP : c.amount;
            st = cda_pkg::STAT_OK;
            if (m < 1 || m > 12 || d < 1 || d > month_length(y, m)
                || y > int'(cda_pkg::MAX_YEAR))
            begin
                st = cda_pkg::STAT_INVALID;
            end
            else if (c.action == cda_pkg::ACT_DAYS || c.action == cda_pkg::ACT_WEEKS)
            begin
                steps = (c.action == cda_pkg::ACT_WEEKS) ? n * 7 : n;
                repeat (steps)
                begin
                    if (d >= month_length(y, m))
                    begin
                        d = 1;
                        if (m >= 12)
                        begin
                            m = 1;
                            y++;
                        end
                        else
                            m++;
                    end
                    else
                        d++;
                end
            end
            else if (c.action == cda_pkg::ACT_MONTHS)
            begin
                repeat (n)
                begin
                    if (m >= 12)
                    begin
                        m = 1;
                        y++;
                    end
                    else
                        m++;
                    if (d > month_length(y, m))
                        d = month_length(y, m);
                end
            end
            else if (c.action != ACT_UNUSED)
            begin
                case (c.action)
                    cda_pkg::ACT_YEARS:     scale = 1;
                    cda_pkg::ACT_DECADES:   scale = 10;
                    cda_pkg::ACT_CENTURIES: scale = 100;
                    default:                scale = 1000;
                endcase
                y = y + n * scale;
                if (m == 2 && d == 29 && !is_leap_year(y))
                    d = 28;
            end
            if (st == cda_pkg::STAT_OK && y > int'(cda_pkg::MAX_YEAR))
                st = cda_pkg::STAT_OVERFLOW;
            if (st != cda_pkg::STAT_OK)
            begin
                d = c.start_day;
                m = c.start_month;
                y = c.start_year;
            end
            r.end_day   = d[4:0];
            r.end_month = m[3:0];
            r.end_year  = y[13:0];
            r.status    = st;
            return r;
        endfunction

        function void note_cmd(input cda_pkg::cda_in_t c);
            due_q.push_back(advance_date(c));
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function bit field_ok(input string name, input int want, input int got);
            if (want == got)
                return 1'b1;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1'b0;
        endfunction

        function void check_res(input cda_pkg::cda_out_t got);
            cda_pkg::cda_out_t want;
            bit                ok;
            if (due_q.size() == 0)
            begin
                $display("%0t: result %0d/%0d/%0d status %0d with no command pending",
                         $time, got.end_day, got.end_month, got.end_year, got.status);
                errors++;
                return;
            end
            want = due_q.pop_front();
            ok = field_ok("end_day", want.end_day, got.end_day);
            ok = field_ok("end_month", want.end_month, got.end_month) && ok;
            ok = field_ok("end_year", want.end_year, got.end_year) && ok;
            ok = field_ok("status", want.status, got.status) && ok;
            if (!ok)
                errors++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle = 1'b0;
    int   quiet_cycles = 0;

    date_scoreboard board = new();

    cda_in_if  cmd_ch ();
    cda_out_if res_ch ();

    calendar_date_adder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #1 clk = ~clk;

    // Receiver: hold off ready about 37 percent of the time, except in the no-idle stretch
    always @(posedge clk)
        res_ch.ready <= no_idle || ($urandom_range(99) >= 37);

    // Check every accepted result; watch for a run that stops moving
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_res(res_ch.data);
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic cda_pkg::cda_in_t make_cmd(input logic [2:0] act, input int d,
                                                  input int m, input int y, input int amt);
        cda_pkg::cda_in_t c;
        c.action      = act;
        c.start_day   = d[4:0];
        c.start_month = m[3:0];
        c.start_year  = y[13:0];
        c.amount      = amt[9:0];
        return c;
    endfunction

    // Build one random command: mostly valid dates with random content, the
    // rest raw noise that can land on invalid dates and the unused unit code
    function automatic cda_pkg::cda_in_t random_cmd();
        cda_pkg::cda_in_t c;
        int               yr;
        int               mon;
        int               len;
        if ($urandom_range(99) < 20)
        begin
            c.action      = 3'($urandom);
            c.start_day   = 5'($urandom);
            c.start_month = 4'($urandom);
            c.start_year  = 14'($urandom);
            c.amount      = 10'($urandom);
            return c;
        end
        c.action = ($urandom_range(99) < 4) ? ACT_UNUSED : 3'($urandom_range(6));
        // Favor years near the top (overflow) and century years (leap rule)
        case ($urandom_range(9))
            0, 1:    yr = 9970 + $urandom_range(29);
            2:       yr = 100 * $urandom_range(99);
            default: yr = $urandom_range(9999);
        endcase
        mon = $urandom_range(1, 12);
        len = date_scoreboard::month_length(yr, mon);
        c.start_year  = yr[13:0];
        c.start_month = mon[3:0];
        c.start_day   = ($urandom_range(4) == 0) ? len[4:0] : 5'($urandom_range(1, len));
        // Feb 29 on a year divisible by four; plain century years make it invalid
        if ($urandom_range(9) == 0)
        begin
            c.start_year  = 14'(4 * $urandom_range(2499));
            c.start_month = 4'd2;
            c.start_day   = 5'd29;
        end
        // Keep amounts small most of the time; large amounts of weeks take longest
        c.amount = ($urandom_range(99) < 8) ? 10'($urandom_range(1023))
                                            : 10'($urandom_range(40));
        return c;
    endfunction

    // Present one command, idling at random first, and hold it until taken
    task automatic send_cmd(input cda_pkg::cda_in_t c);
        while (!no_idle && $urandom_range(99) < 37)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        board.note_cmd(c);
    endtask

    // Drop valid and hold off until every expected result is back
    task automatic wait_all_done();
        cmd_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: amount zero, overflow by a single day, century leap rule, largest day amount
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 1, 1, 0, 0));
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 31, 12, 9999, 1));
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 28, 2, 1900, 1));
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 28, 2, 2000, 1));
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 1, 3, 2023, 1023));
        // Largest amount of weeks, and zero weeks on the last valid date
        send_cmd(make_cmd(cda_pkg::ACT_WEEKS, 1, 1, 2000, 1023));
        send_cmd(make_cmd(cda_pkg::ACT_WEEKS, 31, 12, 9999, 0));
        // Months: clamp to month length, leap February, overflow
        send_cmd(make_cmd(cda_pkg::ACT_MONTHS, 31, 1, 2023, 1));
        send_cmd(make_cmd(cda_pkg::ACT_MONTHS, 31, 1, 2024, 13));
        send_cmd(make_cmd(cda_pkg::ACT_MONTHS, 31, 12, 9998, 1023));
        // Year units: Feb 29 landing on leap and non-leap years, millennia in range and past the top
        send_cmd(make_cmd(cda_pkg::ACT_YEARS, 29, 2, 2024, 1));
        send_cmd(make_cmd(cda_pkg::ACT_DECADES, 29, 2, 1996, 10));
        send_cmd(make_cmd(cda_pkg::ACT_CENTURIES, 29, 2, 2000, 1));
        send_cmd(make_cmd(cda_pkg::ACT_MILLENNIA, 15, 6, 0, 9));
        send_cmd(make_cmd(cda_pkg::ACT_MILLENNIA, 15, 6, 1, 10));
        // Unused unit code, valid and invalid start date
        send_cmd(make_cmd(ACT_UNUSED, 5, 5, 5, 3));
        send_cmd(make_cmd(ACT_UNUSED, 0, 5, 5, 3));
        // Invalid start dates: month zero, month and year at field maximum,
        // day past month end, Feb 29 of a plain century, year past the top, day zero
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 10, 0, 2020, 5));
        send_cmd(make_cmd(cda_pkg::ACT_MONTHS, 31, 15, 16383, 1023));
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 31, 4, 2021, 2));
        send_cmd(make_cmd(cda_pkg::ACT_YEARS, 29, 2, 1900, 4));
        send_cmd(make_cmd(cda_pkg::ACT_WEEKS, 1, 1, 10000, 1));
        send_cmd(make_cmd(cda_pkg::ACT_DAYS, 0, 6, 2022, 1));

        // Hold the sender until the directed results are all back
        wait_all_done();

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            // Run both sides without idling through one stretch
            no_idle = (i >= 30 && i < 50);
            if (i == 70)
                wait_all_done();
            send_cmd(random_cmd());
        end
        no_idle = 1'b0;

        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
